/* hdl/utf8_stream_decoder_assert.svh */
// assertion macros for the utf8 stream decoder
// each macro expects clk and arst_n in the scope of use
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// cond holds at every clock edge out of reset
`define U8SD_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("u8sd invariant violated");

// cons holds in the same cycle as ante
`define U8SD_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u8sd implication violated");

// cons holds in the cycle after ante
`define U8SD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u8sd sequence violated");

`endif

/* hdl/u8sd_pkg.sv */
`default_nettype none
package u8sd_pkg;

	typedef logic [3:0] dfa_state_t;
	typedef logic [3:0] byte_class_t;

	localparam int SEQ_LIMIT_DEFAULT = 4;
	localparam int CP_W              = 21;
	localparam int BYTE_W            = 8;

	// automaton states
	localparam dfa_state_t ST_ACCEPT = 4'd0;
	localparam dfa_state_t ST_REJECT = 4'd1;
	localparam dfa_state_t ST_NEED1  = 4'd2;
	localparam dfa_state_t ST_NEED2  = 4'd3;
	localparam dfa_state_t ST_E0     = 4'd4;
	localparam dfa_state_t ST_ED     = 4'd5;
	localparam dfa_state_t ST_F0     = 4'd6;
	localparam dfa_state_t ST_NEED3  = 4'd7;
	localparam dfa_state_t ST_F4     = 4'd8;

	// byte classes
	localparam byte_class_t CLS_ASCII   = 4'd0;
	localparam byte_class_t CLS_CONT_8X = 4'd1;
	localparam byte_class_t CLS_LEAD2   = 4'd2;
	localparam byte_class_t CLS_LEAD3   = 4'd3;
	localparam byte_class_t CLS_ED      = 4'd4;
	localparam byte_class_t CLS_F4      = 4'd5;
	localparam byte_class_t CLS_F1_F3   = 4'd6;
	localparam byte_class_t CLS_CONT_AX = 4'd7;
	localparam byte_class_t CLS_INVALID = 4'd8;
	localparam byte_class_t CLS_CONT_9X = 4'd9;
	localparam byte_class_t CLS_E0      = 4'd10;
	localparam byte_class_t CLS_F0      = 4'd11;

	localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
	localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

	function automatic byte_class_t byte_class(input logic [BYTE_W-1:0] b);
		byte_class_t c;
		if (b < 8'h80)       c = CLS_ASCII;
		else if (b < 8'h90)  c = CLS_CONT_8X;
		else if (b < 8'hA0)  c = CLS_CONT_9X;
		else if (b < 8'hC0)  c = CLS_CONT_AX;
		else if (b < 8'hC2)  c = CLS_INVALID;
		else if (b < 8'hE0)  c = CLS_LEAD2;
		else if (b == 8'hE0) c = CLS_E0;
		else if (b == 8'hED) c = CLS_ED;
		else if (b < 8'hF0)  c = CLS_LEAD3;
		else if (b == 8'hF0) c = CLS_F0;
		else if (b < 8'hF4)  c = CLS_F1_F3;
		else if (b == 8'hF4) c = CLS_F4;
		else                 c = CLS_INVALID;
		return c;
	endfunction

	// transition table, state above range must be clamped by the caller
	function automatic dfa_state_t next_state(input dfa_state_t st, input byte_class_t cls);
		dfa_state_t n;
		n = ST_REJECT;
		unique case (st)
			ST_ACCEPT: begin
				case (cls) inside
					CLS_ASCII:         n = ST_ACCEPT;
					CLS_LEAD2:         n = ST_NEED1;
					CLS_LEAD3:         n = ST_NEED2;
					CLS_ED:            n = ST_ED;
					CLS_F4:            n = ST_F4;
					CLS_F1_F3:         n = ST_NEED3;
					CLS_E0:            n = ST_E0;
					CLS_F0:            n = ST_F0;
					default:           n = ST_REJECT;
				endcase
			end
			ST_NEED1: begin
				case (cls) inside
					CLS_CONT_8X, CLS_CONT_9X, CLS_CONT_AX: n = ST_ACCEPT;
					default:                               n = ST_REJECT;
				endcase
			end
			ST_NEED2: begin
				case (cls) inside
					CLS_CONT_8X, CLS_CONT_9X, CLS_CONT_AX: n = ST_NEED1;
					default:                               n = ST_REJECT;
				endcase
			end
			ST_E0: begin
				case (cls) inside
					CLS_CONT_AX: n = ST_NEED1;
					default:     n = ST_REJECT;
				endcase
			end
			ST_ED: begin
				case (cls) inside
					CLS_CONT_8X, CLS_CONT_9X: n = ST_NEED1;
					default:                  n = ST_REJECT;
				endcase
			end
			ST_F0: begin
				case (cls) inside
					CLS_CONT_9X, CLS_CONT_AX: n = ST_NEED2;
					default:                  n = ST_REJECT;
				endcase
			end
			ST_NEED3: begin
				case (cls) inside
					CLS_CONT_8X, CLS_CONT_9X, CLS_CONT_AX: n = ST_NEED2;
					default:                               n = ST_REJECT;
				endcase
			end
			ST_F4: begin
				case (cls) inside
					CLS_CONT_8X: n = ST_NEED2;
					default:     n = ST_REJECT;
				endcase
			end
			default: n = ST_REJECT;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

/* hdl/utf8_stream_decoder.sv */
// utf8 stream decoder
// input channel s_*: one raw byte per beat on s_tdata[7:0]
// output channel m_*: one decoded character per beat, code point on m_tdata[20:0],
//   m_tuser[0] marks a replacement beat (code point zero then)
// config port: cfg_we with cfg_wdata writes utf8_mode (1 decodes utf8, 0 passes
//   printable ascii only); a write clears the sequence state, write only when idle
// a byte may produce no beat (bytes inside a sequence, dropped bytes)
// a taken byte is held in the input stage, then any result in the result register
// throughput: one byte per cycle while the result register is free or drains,
//   set by the single pass through class lookup, transition table and
//   accumulator shift between the byte register and the result register
// reset: utf8 mode on, automaton in accept state, accumulator and count clear,
//   both stages empty
// stall: while m_tready is low and a result waits, one more byte is held in the
//   input stage; s_tready then drops until the result beat is taken
`default_nettype none
`include "utf8_stream_decoder_assert.svh"
module utf8_stream_decoder #(
	parameter int SEQ_LIMIT = u8sd_pkg::SEQ_LIMIT_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,     // utf8_mode
	// byte input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,       // [7:0] in_byte
	// character output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,       // [20:0] code_point, [23:21] zero
	output logic [0:0]       m_tuser        // [0] is_replacement
);

	localparam int CNT_W = $clog2(SEQ_LIMIT + 1);
	localparam int CP_W  = u8sd_pkg::CP_W;
	localparam int BW    = u8sd_pkg::BYTE_W;
	localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(SEQ_LIMIT);

	// mode and sequence state
	logic                   utf8_mode_q;
	u8sd_pkg::dfa_state_t   dfa_q;
	logic [CP_W-1:0]        accum_q;
	logic [CNT_W-1:0]       count_q;

	// input stage
	logic                   valid_s1;
	logic [BW-1:0]          byte_s1;

	// result register
	logic                   out_valid_q;
	logic [CP_W-1:0]        out_cp_q;
	logic                   out_repl_q;

	// next-state logic
	logic                   advance;
	logic                   emit;
	logic                   emit_repl;
	logic [CP_W-1:0]        emit_cp;
	u8sd_pkg::dfa_state_t   st_eff;
	u8sd_pkg::byte_class_t  cls;
	u8sd_pkg::dfa_state_t   dfa_nxt;
	logic [CP_W-1:0]        accum_nxt;
	logic [CNT_W-1:0]       count_nxt;
	logic [BW-1:0]          lead_bits;

	// the input stage moves on when the result register is free or drains now
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_cp_q};
	assign m_tuser  = out_repl_q;

	always_comb begin
		// a state above the table range acts as reject
		st_eff    = (dfa_q > u8sd_pkg::ST_F4) ? u8sd_pkg::ST_REJECT : dfa_q;
		cls       = u8sd_pkg::byte_class(byte_s1);
		lead_bits = (8'hFF >> cls) & byte_s1;
		emit      = 1'b0;
		emit_repl = 1'b0;
		emit_cp   = CP_W'(byte_s1);
		dfa_nxt   = dfa_q;
		accum_nxt = accum_q;
		count_nxt = count_q;
		if (!utf8_mode_q) begin
			// pass mode: printable ascii only, sequence state untouched
			emit = (byte_s1 >= u8sd_pkg::PRINT_LO) && (byte_s1 <= u8sd_pkg::PRINT_HI);
		end else if (count_q >= LIMIT_C) begin
			// limit reached: drop this byte and send the replacement marker
			emit      = 1'b1;
			emit_repl = 1'b1;
			emit_cp   = '0;
			dfa_nxt   = u8sd_pkg::ST_ACCEPT;
			accum_nxt = '0;
			count_nxt = '0;
		end else begin
			count_nxt = CNT_W'(count_q + 1'b1);
			if (st_eff != u8sd_pkg::ST_ACCEPT)
				accum_nxt = {accum_q[CP_W-7:0], byte_s1[5:0]};
			else
				accum_nxt = CP_W'(lead_bits);
			dfa_nxt = u8sd_pkg::next_state(st_eff, cls);
			if (dfa_nxt == u8sd_pkg::ST_ACCEPT) begin
				emit      = 1'b1;
				emit_cp   = accum_nxt;
				accum_nxt = '0;
				count_nxt = '0;
			end
		end
	end

	// mode and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_mode_q <= 1'b1;
			dfa_q       <= u8sd_pkg::ST_ACCEPT;
			accum_q     <= '0;
			count_q     <= '0;
		end else if (cfg_we) begin
			utf8_mode_q <= cfg_wdata;
			dfa_q       <= u8sd_pkg::ST_ACCEPT;
			accum_q     <= '0;
			count_q     <= '0;
		end else if (advance) begin
			dfa_q       <= dfa_nxt;
			accum_q     <= accum_nxt;
			count_q     <= count_nxt;
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_cp_q   <= emit_cp;
			out_repl_q <= emit_repl;
		end
	end

	`U8SD_ASSERT_ALWAYS(a_count_in_range, count_q <= LIMIT_C)
	`U8SD_ASSERT_IMPLIES(a_accept_is_clear, dfa_q == u8sd_pkg::ST_ACCEPT, (count_q == '0) && (accum_q == '0))
	`U8SD_ASSERT_IMPLIES(a_repl_zero_cp, out_valid_q && out_repl_q, out_cp_q == '0)
	`U8SD_ASSERT_NEXT(a_s1_held_on_stall, valid_s1 && out_valid_q && !m_tready, valid_s1 && $stable(byte_s1))

endmodule
`default_nettype wire

/* tb/utf8_decode_checker.sv */
`timescale 1ns / 1ps
module utf8_decode_checker #(
	parameter int SEQ_LIMIT = u8sd_pkg::SEQ_LIMIT_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] in_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,     // [20:0] code_point, [23:21] zero
	input  logic [0:0]  m_tuser,     // [0] is_replacement
	output int          n_fail,
	output int          pending
);

	localparam int CP_W = u8sd_pkg::CP_W;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_replacement;
	} char_t;

	char_t           char_queue[$];
	char_t           head;
	char_t           fresh;
	bit              fresh_ok;

	// decoder state as the block should hold it
	logic                 utf8_on;
	u8sd_pkg::dfa_state_t dfa;
	logic [CP_W-1:0]      accum;
	logic [3:0]           seq_len;

	function automatic u8sd_pkg::dfa_state_t next_dfa(input u8sd_pkg::dfa_state_t st,
			input logic [7:0] b);
		u8sd_pkg::dfa_state_t nx;
		logic                 cont;
		cont = (b[7:6] == 2'b10);
		nx = u8sd_pkg::ST_REJECT;
		case (st)
			u8sd_pkg::ST_ACCEPT: begin
				if (b < 8'h80)       nx = u8sd_pkg::ST_ACCEPT;
				else if (b < 8'hC2)  nx = u8sd_pkg::ST_REJECT;
				else if (b < 8'hE0)  nx = u8sd_pkg::ST_NEED1;
				else if (b == 8'hE0) nx = u8sd_pkg::ST_E0;
				else if (b == 8'hED) nx = u8sd_pkg::ST_ED;
				else if (b < 8'hF0)  nx = u8sd_pkg::ST_NEED2;
				else if (b == 8'hF0) nx = u8sd_pkg::ST_F0;
				else if (b < 8'hF4)  nx = u8sd_pkg::ST_NEED3;
				else if (b == 8'hF4) nx = u8sd_pkg::ST_F4;
			end
			u8sd_pkg::ST_NEED1: if (cont) nx = u8sd_pkg::ST_ACCEPT;
			u8sd_pkg::ST_NEED2: if (cont) nx = u8sd_pkg::ST_NEED1;
			u8sd_pkg::ST_NEED3: if (cont) nx = u8sd_pkg::ST_NEED2;
			// restricted second bytes: no overlongs, no surrogates, nothing past 10ffff
			u8sd_pkg::ST_E0:    if (b >= 8'hA0 && b <= 8'hBF) nx = u8sd_pkg::ST_NEED1;
			u8sd_pkg::ST_ED:    if (cont && b < 8'hA0) nx = u8sd_pkg::ST_NEED1;
			u8sd_pkg::ST_F0:    if (b >= 8'h90 && b <= 8'hBF) nx = u8sd_pkg::ST_NEED2;
			u8sd_pkg::ST_F4:    if (cont && b < 8'h90) nx = u8sd_pkg::ST_NEED2;
			default:            nx = u8sd_pkg::ST_REJECT;
		endcase
		return nx;
	endfunction

	function automatic void clear_seq();
		dfa = u8sd_pkg::ST_ACCEPT;
		accum = '0;
		seq_len = '0;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, output bit got, output char_t ch);
		u8sd_pkg::dfa_state_t st;
		u8sd_pkg::dfa_state_t nx;
		got = 1'b0;
		ch = '0;
		if (!utf8_on) begin
			if (b >= u8sd_pkg::PRINT_LO && b <= u8sd_pkg::PRINT_HI) begin
				got = 1'b1;
				ch.code_point = CP_W'(b);
			end
			return;
		end
		// buffer full: drop the byte, emit the marker
		if (seq_len >= SEQ_LIMIT) begin
			clear_seq();
			got = 1'b1;
			ch.is_replacement = 1'b1;
			return;
		end
		seq_len = seq_len + 4'd1;
		st = (dfa > u8sd_pkg::ST_F4) ? u8sd_pkg::ST_REJECT : dfa;
		nx = next_dfa(st, b);
		if (st != u8sd_pkg::ST_ACCEPT) begin
			accum = {accum[CP_W-7:0], b[5:0]};
		end else begin
			// payload bits of the lead byte; rejected leads never reach the output
			case (nx)
				u8sd_pkg::ST_ACCEPT: accum = CP_W'(b);
				u8sd_pkg::ST_NEED1:  accum = CP_W'(b & 8'h1F);
				u8sd_pkg::ST_NEED2, u8sd_pkg::ST_E0, u8sd_pkg::ST_ED:
					accum = CP_W'(b & 8'h0F);
				u8sd_pkg::ST_NEED3, u8sd_pkg::ST_F0, u8sd_pkg::ST_F4:
					accum = CP_W'(b & 8'h07);
				default:             accum = '0;
			endcase
		end
		dfa = nx;
		if (nx == u8sd_pkg::ST_ACCEPT) begin
			got = 1'b1;
			ch.code_point = accum;
			clear_seq();
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [23:0] want,
			input logic [23:0] got);
		if (n_fail < 10)
			$display("%t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
		n_fail++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_queue.delete();
			utf8_on = 1'b1;
			clear_seq();
			n_fail = 0;
			pending <= 0;
		end else begin
			// results first: a beat out can never belong to a byte taken at the same edge
			if (m_tvalid && m_tready) begin
				if (char_queue.size() == 0) begin
					if (n_fail < 10)
						$display("%t unexpected beat: tdata 0x%0h tuser %0b",
							$realtime, m_tdata, m_tuser);
					n_fail++;
				end else begin
					head = char_queue.pop_front();
					if (m_tdata !== {3'b000, head.code_point})
						report_mismatch("code point", {3'b000, head.code_point}, m_tdata);
					if (m_tuser[0] !== head.is_replacement)
						report_mismatch("replacement flag", 24'(head.is_replacement),
							24'(m_tuser));
				end
			end
			if (cfg_we) begin
				utf8_on = cfg_wdata;
				clear_seq();
			end
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, fresh_ok, fresh);
				if (fresh_ok)
					char_queue.push_back(fresh);
			end
			pending <= char_queue.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;

	localparam int SEQ_LIMIT    = u8sd_pkg::SEQ_LIMIT_DEFAULT;
	// cycles without any beat on either side before the run is called hung
	localparam int STALL_LIMIT  = 2000;
	// covers the input stage and the result stage, plus margin
	localparam int DRAIN_CYCLES = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;   // [7:0] in_byte
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;            // [20:0] code_point, [23:21] zero
	logic [0:0]  m_tuser;            // [0] is_replacement

	int n_fail;
	int pending;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int bytes_sent     = 0;
	int quiet_cycles   = 0;

	// valid sequences at both ends of the range, then a bad lead that gets
	// swallowed together with the next bytes until the marker comes out
	logic [7:0] utf8_directed [] = '{
		8'h00, 8'h7F,
		8'hC2, 8'h80,
		8'hDF, 8'hBF,
		8'hE0, 8'hA0, 8'h80,
		8'hED, 8'h9F, 8'hBF,
		8'hF0, 8'h90, 8'h80, 8'h80,
		8'hF4, 8'h8F, 8'hBF, 8'hBF,
		8'hFF, 8'h41, 8'h42, 8'h43, 8'h44
	};

	// printable window edges and bytes just outside it
	logic [7:0] pass_directed [] = '{
		8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'hFF
	};

	utf8_stream_decoder #(
		.SEQ_LIMIT(SEQ_LIMIT)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	utf8_decode_checker #(
		.SEQ_LIMIT(SEQ_LIMIT)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.n_fail    (n_fail),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver backpressure, redrawn every cycle
	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// hang detection: any beat on either side resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// one byte beat, with random idle cycles in front of it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	function automatic logic [7:0] rand_byte(input int lo, input int hi);
		return 8'($urandom_range(hi, lo));
	endfunction

	// mostly well-formed characters of every length and lead class,
	// the rest broken pairs and loose bytes
	task automatic send_utf8_char();
		logic [7:0] seq [4];
		int         len;
		int         pick;
		pick = $urandom_range(0, 99);
		len = 1;
		seq[1] = rand_byte(8'h80, 8'hBF);
		seq[2] = rand_byte(8'h80, 8'hBF);
		seq[3] = rand_byte(8'h80, 8'hBF);
		if (pick < 25) begin
			seq[0] = rand_byte(8'h00, 8'h7F);
		end else if (pick < 40) begin
			len = 2;
			seq[0] = rand_byte(8'hC2, 8'hDF);
		end else if (pick < 50) begin
			// generic three-byte lead, skipping the surrogate lead
			len = 3;
			seq[0] = rand_byte(8'hE1, 8'hEF);
			if (seq[0] == 8'hED)
				seq[0] = 8'hEE;
		end else if (pick < 55) begin
			len = 3;
			seq[0] = 8'hE0;
			seq[1] = rand_byte(8'hA0, 8'hBF);
		end else if (pick < 60) begin
			len = 3;
			seq[0] = 8'hED;
			seq[1] = rand_byte(8'h80, 8'h9F);
		end else if (pick < 65) begin
			len = 4;
			seq[0] = 8'hF0;
			seq[1] = rand_byte(8'h90, 8'hBF);
		end else if (pick < 72) begin
			len = 4;
			seq[0] = rand_byte(8'hF1, 8'hF3);
		end else if (pick < 77) begin
			len = 4;
			seq[0] = 8'hF4;
			seq[1] = rand_byte(8'h80, 8'h8F);
		end else if (pick < 87) begin
			// lead byte followed by anything: bad second bytes, truncations
			len = 2;
			seq[0] = rand_byte(8'hC0, 8'hFF);
			seq[1] = rand_byte(8'h00, 8'hFF);
		end else begin
			seq[0] = rand_byte(8'h00, 8'hFF);
		end
		for (int i = 0; i < len; i++)
			send_byte(seq[i]);
	endtask

	// stop sending and wait until every predicted char has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// mode writes only on an idle block; a byte with no result may still be in flight
	task automatic write_mode(input logic mode);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one phase: mode write, idle profile, random traffic with a full drain halfway
	task automatic run_phase(input logic mode, input int s_idle, input int r_stall,
			input int n_bytes);
		int half_mark;
		int end_mark;
		write_mode(mode);
		send_idle_pct  = s_idle;
		recv_stall_pct = r_stall;
		half_mark = bytes_sent + n_bytes / 2;
		end_mark  = bytes_sent + n_bytes;
		if (!mode)
			foreach (pass_directed[i]) send_byte(pass_directed[i]);
		for (int part = 0; part < 2; part++) begin
			while (bytes_sent < ((part == 0) ? half_mark : end_mark)) begin
				if (mode)
					send_utf8_char();
				else
					send_byte(rand_byte(8'h00, 8'hFF));
			end
			// sender holds off until the output side has caught up
			if (part == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// decoding mode straight out of reset
		foreach (utf8_directed[i]) send_byte(utf8_directed[i]);

		run_phase(1'b1, 0, 0, 350);
		run_phase(1'b1, 62, 0, 300);
		run_phase(1'b0, 0, 62, 200);
		run_phase(1'b1, 28, 28, 350);
		run_phase(1'b0, 0, 0, 100);
		run_phase(1'b1, 0, 62, 150);

		wait_drained();
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/u8sd_pkg.sv
hdl/utf8_stream_decoder.sv
tb/utf8_decode_checker.sv
tb/tb.sv
